/* hw/rtl/pms_pkg.sv */
// Shared types and constants of the polygon separation block.
package pms_pkg;

    localparam int COORD_W = 32;
    localparam int EDGE_W  = 33;
    localparam int SEP_W   = 34;

    localparam logic [1:0] IN_CLEAR   = 2'd0;
    localparam logic [1:0] IN_APP_A   = 2'd1;
    localparam logic [1:0] IN_APP_B   = 2'd2;
    localparam logic [1:0] IN_COMPUTE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_A_SHORT  = 2'd1;
    localparam logic [1:0] ST_B_EMPTY  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [4:0] OP_NOP    = 5'd0;
    localparam logic [4:0] OP_CLEAR  = 5'd1;
    localparam logic [4:0] OP_APP_A  = 5'd2;
    localparam logic [4:0] OP_APP_B  = 5'd3;
    localparam logic [4:0] OP_START  = 5'd4;
    localparam logic [4:0] OP_RD_A   = 5'd5;
    localparam logic [4:0] OP_LAT_A  = 5'd6;
    localparam logic [4:0] OP_EDGE   = 5'd7;
    localparam logic [4:0] OP_NORM   = 5'd8;
    localparam logic [4:0] OP_SQ     = 5'd9;
    localparam logic [4:0] OP_RAD    = 5'd10;
    localparam logic [4:0] OP_SQRT   = 5'd11;
    localparam logic [4:0] OP_DIVI   = 5'd12;
    localparam logic [4:0] OP_DIV    = 5'd13;
    localparam logic [4:0] OP_UNIT   = 5'd14;
    localparam logic [4:0] OP_RD_B   = 5'd15;
    localparam logic [4:0] OP_DIFF   = 5'd16;
    localparam logic [4:0] OP_MUL    = 5'd17;
    localparam logic [4:0] OP_DOT    = 5'd18;
    localparam logic [4:0] OP_PROJ   = 5'd19;
    localparam logic [4:0] OP_CMP    = 5'd20;
    localparam logic [4:0] OP_BEST   = 5'd21;
    localparam logic [4:0] OP_NEXT   = 5'd22;
    localparam logic [4:0] OP_RESULT = 5'd23;

    typedef struct packed {
        logic [4:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic a_short;
        logic b_empty;
        logic step_last;
        logic j_last;
        logic i_last;
        logic sep_pos;
        logic out_free;
    } t_dp_sts;

endpackage

/* hw/rtl/pms_if.sv */
// Handshake interfaces of the input, result and configuration channels.
interface pms_in_if;
    import pms_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [1:0]                opcode;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    modport source (output valid, opcode, vertex_x, vertex_y, input ready);
    modport sink   (input valid, opcode, vertex_x, vertex_y, output ready);
endinterface

interface pms_out_if;
    import pms_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [SEP_W-1:0]   separation;
    logic signed [EDGE_W-1:0]  edge_x;
    logic signed [EDGE_W-1:0]  edge_y;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [1:0]                status;
    modport source (output valid, separation, edge_x, edge_y, point_x, point_y, status,
                    input ready);
    modport sink   (input valid, separation, edge_x, edge_y, point_x, point_y, status,
                    output ready);
endinterface

interface pms_cfg_if;
    logic valid;
    logic ready;
    logic normal_orientation;
    modport source (output valid, normal_orientation, input ready);
    modport sink   (input valid, normal_orientation, output ready);
endinterface

/* hw/rtl/pms_ctrl.sv */
// Sequencer of the polygon separation block: issues datapath commands.
module pms_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_in_opcode,
    output logic            o_in_ready,
    output pms_pkg::t_dp_cmd o_cmd,
    input  pms_pkg::t_dp_sts i_sts
);
    import pms_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHECK = 5'd1;
    localparam logic [4:0] S_RD_A  = 5'd2;
    localparam logic [4:0] S_LAT_A = 5'd3;
    localparam logic [4:0] S_EDGE  = 5'd4;
    localparam logic [4:0] S_NORM  = 5'd5;
    localparam logic [4:0] S_SQ    = 5'd6;
    localparam logic [4:0] S_RAD   = 5'd7;
    localparam logic [4:0] S_SQRT  = 5'd8;
    localparam logic [4:0] S_DIVI  = 5'd9;
    localparam logic [4:0] S_DIV   = 5'd10;
    localparam logic [4:0] S_UNIT  = 5'd11;
    localparam logic [4:0] S_RD_B  = 5'd12;
    localparam logic [4:0] S_DIFF  = 5'd13;
    localparam logic [4:0] S_MUL   = 5'd14;
    localparam logic [4:0] S_DOT   = 5'd15;
    localparam logic [4:0] S_PROJ  = 5'd16;
    localparam logic [4:0] S_CMP   = 5'd17;
    localparam logic [4:0] S_BEST  = 5'd18;
    localparam logic [4:0] S_NEXT  = 5'd19;
    localparam logic [4:0] S_OUT   = 5'd20;

    logic [4:0] r_state;
    logic [4:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_opcode)
                        IN_CLEAR:   o_cmd.op = OP_CLEAR;
                        IN_APP_A:   o_cmd.op = OP_APP_A;
                        IN_APP_B:   o_cmd.op = OP_APP_B;
                        IN_COMPUTE: n_state  = S_CHECK;
                        default:    o_cmd.op = OP_NOP;
                    endcase
                end
            end
            S_CHECK: begin
                o_cmd.op = OP_START;
                n_state  = (i_sts.a_short || i_sts.b_empty) ? S_OUT : S_RD_A;
            end
            S_RD_A:  begin o_cmd.op = OP_RD_A;  n_state = S_LAT_A; end
            S_LAT_A: begin o_cmd.op = OP_LAT_A; n_state = S_EDGE;  end
            S_EDGE:  begin o_cmd.op = OP_EDGE;  n_state = S_NORM;  end
            S_NORM:  begin o_cmd.op = OP_NORM;  n_state = S_SQ;    end
            S_SQ:    begin o_cmd.op = OP_SQ;    n_state = S_RAD;   end
            S_RAD:   begin o_cmd.op = OP_RAD;   n_state = S_SQRT;  end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                if (i_sts.step_last) n_state = S_DIVI;
            end
            S_DIVI:  begin o_cmd.op = OP_DIVI;  n_state = S_DIV;   end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_sts.step_last) n_state = S_UNIT;
            end
            S_UNIT:  begin o_cmd.op = OP_UNIT;  n_state = S_RD_B;  end
            S_RD_B:  begin o_cmd.op = OP_RD_B;  n_state = S_DIFF;  end
            S_DIFF:  begin o_cmd.op = OP_DIFF;  n_state = S_MUL;   end
            S_MUL:   begin o_cmd.op = OP_MUL;   n_state = S_DOT;   end
            S_DOT:   begin o_cmd.op = OP_DOT;   n_state = S_PROJ;  end
            S_PROJ:  begin o_cmd.op = OP_PROJ;  n_state = S_CMP;   end
            S_CMP: begin
                o_cmd.op = OP_CMP;
                n_state  = i_sts.j_last ? S_BEST : S_RD_B;
            end
            S_BEST:  begin o_cmd.op = OP_BEST;  n_state = S_NEXT;  end
            S_NEXT: begin
                if (i_sts.sep_pos || i_sts.i_last) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = OP_NEXT;
                    n_state  = S_RD_A;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_RESULT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hw/rtl/pms_datapath.sv */
// Datapath of the polygon separation block: vertex stores, norm unit, projections.
module pms_datapath #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pms_pkg::t_dp_cmd                   i_cmd,
    output pms_pkg::t_dp_sts                   o_sts,
    input  logic signed [pms_pkg::COORD_W-1:0] i_vertex_x,
    input  logic signed [pms_pkg::COORD_W-1:0] i_vertex_y,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_data,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic signed [pms_pkg::SEP_W-1:0]   o_separation,
    output logic signed [pms_pkg::EDGE_W-1:0]  o_edge_x,
    output logic signed [pms_pkg::EDGE_W-1:0]  o_edge_y,
    output logic signed [pms_pkg::COORD_W-1:0] o_point_x,
    output logic signed [pms_pkg::COORD_W-1:0] o_point_y,
    output logic [1:0]                         o_status
);
    import pms_pkg::*;

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic [63:0]   r_mem_a [MAX_VERTICES];
    logic [63:0]   r_mem_b [MAX_VERTICES];
    logic [63:0]   r_rd_a;
    logic [63:0]   r_rd_b;
    logic [CW-1:0] r_cnt_a;
    logic [CW-1:0] r_cnt_b;
    logic          r_ovf;
    logic          r_orient;
    logic [IW-1:0] r_i;
    logic [IW-1:0] r_j;
    logic          r_have;
    logic          r_mhave;

    logic signed [31:0] r_ax;
    logic signed [31:0] r_ay;
    logic signed [32:0] r_ex;
    logic signed [32:0] r_ey;
    logic [30:0]        r_ma;
    logic [30:0]        r_mb;
    logic               r_negx;
    logic               r_negy;
    logic [61:0]        r_pa;
    logic [61:0]        r_pb;
    logic [63:0]        r_rad;
    logic [63:0]        r_root;
    logic [63:0]        r_bit;
    logic [5:0]         r_step;
    logic [31:0]        r_len;
    logic [31:0]        r_rem_a;
    logic [31:0]        r_rem_b;
    logic [30:0]        r_dva;
    logic [30:0]        r_dvb;
    logic [30:0]        r_qa;
    logic [30:0]        r_qb;
    logic [30:0]        r_mux;
    logic [30:0]        r_muy;
    logic               r_sux;
    logic               r_suy;
    logic [31:0]        r_bx;
    logic [31:0]        r_by;
    logic [31:0]        r_mdx;
    logic [31:0]        r_mdy;
    logic               r_sdx;
    logic               r_sdy;
    logic [62:0]        r_prx;
    logic [62:0]        r_pry;
    logic               r_psx;
    logic               r_psy;
    logic signed [63:0] r_dot;
    logic signed [33:0] r_proj;
    logic signed [33:0] r_msep;
    logic [31:0]        r_mx;
    logic [31:0]        r_my;
    logic signed [33:0] r_sep;
    logic signed [32:0] r_bex;
    logic signed [32:0] r_bey;
    logic [31:0]        r_px;
    logic [31:0]        r_py;
    logic [1:0]         r_status;
    logic               r_o_valid;

    logic [IW-1:0]      nxt;
    logic [IW-1:0]      rd_addr_a;
    logic signed [32:0] mag_ex;
    logic signed [32:0] mag_ey;
    logic               shr;
    logic [63:0]        trial;
    logic [32:0]        ta;
    logic [32:0]        tb;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [63:0] tx;
    logic signed [63:0] ty;
    logic [63:0]        mdot;
    logic signed [33:0] mproj;
    logic               len_zero;

    assign o_sts.a_short   = (r_cnt_a < CW'(3));
    assign o_sts.b_empty   = (r_cnt_b == '0);
    assign o_sts.step_last = (r_step == '0);
    assign o_sts.j_last    = (CW'(r_j) == r_cnt_b - CW'(1));
    assign o_sts.i_last    = (CW'(r_i) == r_cnt_a - CW'(1));
    assign o_sts.sep_pos   = !r_sep[33] && (r_sep != '0);
    assign o_sts.out_free  = !r_o_valid || i_out_ready;

    assign nxt       = o_sts.i_last ? '0 : r_i + IW'(1);
    assign rd_addr_a = (i_cmd.op == OP_LAT_A) ? nxt : r_i;

    always_comb begin
        mag_ex   = r_ex[32] ? -r_ex : r_ex;
        mag_ey   = r_ey[32] ? -r_ey : r_ey;
        shr      = mag_ey[31] | mag_ex[31];
        trial    = r_root + r_bit;
        ta       = {r_rem_a, r_dva[30]};
        tb       = {r_rem_b, r_dvb[30]};
        dx       = {r_rd_b[63], r_rd_b[63:32]} - {r_ax[31], r_ax};
        dy       = {r_rd_b[31], r_rd_b[31:0]} - {r_ay[31], r_ay};
        tx       = r_psx ? -$signed({1'b0, r_prx}) : $signed({1'b0, r_prx});
        ty       = r_psy ? -$signed({1'b0, r_pry}) : $signed({1'b0, r_pry});
        mdot     = r_dot[63] ? 64'(-r_dot) : 64'(r_dot);
        mproj    = $signed({1'b0, mdot[62:30]});
        len_zero = (r_len == '0);
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem_a[rd_addr_a];
        r_rd_b <= r_mem_b[r_j];
        if (i_cmd.op == OP_APP_A && r_cnt_a < CW'(MAX_VERTICES)) begin
            r_mem_a[r_cnt_a[IW-1:0]] <= {i_vertex_x, i_vertex_y};
        end
        if (i_cmd.op == OP_APP_B && r_cnt_b < CW'(MAX_VERTICES)) begin
            r_mem_b[r_cnt_b[IW-1:0]] <= {i_vertex_x, i_vertex_y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a   <= '0;
            r_cnt_b   <= '0;
            r_ovf     <= 1'b0;
            r_orient  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_orient <= i_cfg_data;
            if (i_cmd.op == OP_RESULT)          r_o_valid <= 1'b1;
            else if (r_o_valid && i_out_ready) r_o_valid <= 1'b0;
            case (i_cmd.op)
                OP_CLEAR: begin
                    r_cnt_a <= '0;
                    r_cnt_b <= '0;
                    r_ovf   <= 1'b0;
                end
                OP_APP_A: begin
                    if (r_cnt_a < CW'(MAX_VERTICES)) r_cnt_a <= r_cnt_a + CW'(1);
                    else                             r_ovf   <= 1'b1;
                end
                OP_APP_B: begin
                    if (r_cnt_b < CW'(MAX_VERTICES)) r_cnt_b <= r_cnt_b + CW'(1);
                    else                             r_ovf   <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_START: begin
                r_i    <= '0;
                r_have <= 1'b0;
                r_sep  <= '0;
                r_bex  <= '0;
                r_bey  <= '0;
                r_px   <= '0;
                r_py   <= '0;
                if (o_sts.a_short)      r_status <= ST_A_SHORT;
                else if (o_sts.b_empty) r_status <= ST_B_EMPTY;
                else if (r_ovf)         r_status <= ST_OVERFLOW;
                else                    r_status <= ST_OK;
            end
            OP_LAT_A: begin
                r_ax <= $signed(r_rd_a[63:32]);
                r_ay <= $signed(r_rd_a[31:0]);
            end
            OP_EDGE: begin
                r_ex <= {r_rd_a[63], r_rd_a[63:32]} - {r_ax[31], r_ax};
                r_ey <= {r_rd_a[31], r_rd_a[31:0]} - {r_ay[31], r_ay};
            end
            OP_NORM: begin
                r_ma   <= shr ? mag_ey[31:1] : mag_ey[30:0];
                r_mb   <= shr ? mag_ex[31:1] : mag_ex[30:0];
                r_negx <= r_orient ? (!r_ey[32] && r_ey != '0) : r_ey[32];
                r_negy <= r_orient ? r_ex[32] : (!r_ex[32] && r_ex != '0);
            end
            OP_SQ: begin
                r_pa <= r_ma * r_ma;
                r_pb <= r_mb * r_mb;
            end
            OP_RAD: begin
                r_rad  <= {2'b00, r_pa} + {2'b00, r_pb};
                r_root <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
                r_step <= 6'd31;
            end
            OP_SQRT: begin
                if (r_rad >= trial) begin
                    r_rad  <= r_rad - trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit  <= r_bit >> 2;
                r_step <= r_step - 6'd1;
            end
            OP_DIVI: begin
                r_len   <= r_root[31:0];
                r_rem_a <= {2'b00, r_ma[30:1]};
                r_rem_b <= {2'b00, r_mb[30:1]};
                r_dva   <= {r_ma[0], 30'd0};
                r_dvb   <= {r_mb[0], 30'd0};
                r_qa    <= '0;
                r_qb    <= '0;
                r_step  <= 6'd30;
            end
            OP_DIV: begin
                if (ta >= {1'b0, r_len}) begin
                    r_rem_a <= 32'(ta - {1'b0, r_len});
                    r_qa    <= {r_qa[29:0], 1'b1};
                end else begin
                    r_rem_a <= ta[31:0];
                    r_qa    <= {r_qa[29:0], 1'b0};
                end
                if (tb >= {1'b0, r_len}) begin
                    r_rem_b <= 32'(tb - {1'b0, r_len});
                    r_qb    <= {r_qb[29:0], 1'b1};
                end else begin
                    r_rem_b <= tb[31:0];
                    r_qb    <= {r_qb[29:0], 1'b0};
                end
                r_dva  <= r_dva << 1;
                r_dvb  <= r_dvb << 1;
                r_step <= r_step - 6'd1;
            end
            OP_UNIT: begin
                r_mux   <= len_zero ? '0 : r_qa;
                r_muy   <= len_zero ? '0 : r_qb;
                r_sux   <= r_negx;
                r_suy   <= r_negy;
                r_j     <= '0;
                r_mhave <= 1'b0;
            end
            OP_DIFF: begin
                r_bx  <= r_rd_b[63:32];
                r_by  <= r_rd_b[31:0];
                r_mdx <= dx[32] ? 32'(-dx) : dx[31:0];
                r_mdy <= dy[32] ? 32'(-dy) : dy[31:0];
                r_sdx <= dx[32];
                r_sdy <= dy[32];
            end
            OP_MUL: begin
                r_prx <= r_mdx * r_mux;
                r_pry <= r_mdy * r_muy;
                r_psx <= r_sdx ^ r_sux;
                r_psy <= r_sdy ^ r_suy;
            end
            OP_DOT:  r_dot  <= tx + ty;
            OP_PROJ: r_proj <= r_dot[63] ? -mproj : mproj;
            OP_CMP: begin
                if (!r_mhave || r_proj < r_msep) begin
                    r_msep <= r_proj;
                    r_mx   <= r_bx;
                    r_my   <= r_by;
                end
                r_mhave <= 1'b1;
                r_j     <= r_j + IW'(1);
            end
            OP_BEST: begin
                if (!r_have || r_msep > r_sep) begin
                    r_sep <= r_msep;
                    r_bex <= r_ex;
                    r_bey <= r_ey;
                    r_px  <= r_mx;
                    r_py  <= r_my;
                end
                r_have <= 1'b1;
            end
            OP_NEXT: r_i <= nxt;
            OP_RESULT: begin
                o_separation <= r_sep;
                o_edge_x     <= r_bex;
                o_edge_y     <= r_bey;
                o_point_x    <= $signed(r_px);
                o_point_y    <= $signed(r_py);
                o_status     <= r_status;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_o_valid;

endmodule

/* hw/rtl/polygon_min_separation.sv */
// Top level of the polygon separation block: sequencer, datapath and channels.
// Clear and append words are taken in the idle state and leave the block ready to take another word.
// A compute word runs, for each visited A edge, the 32-step square root, the 31-step
// divider and a projection loop over every B vertex (read, difference, multiply, dot, project, compare).
// An invalid polygon pair goes from the check state straight to the output state, skipping the edge loop.
// Synchronous active-low reset empties both polygons and clears the orientation.
module polygon_min_separation #(
    parameter int MAX_VERTICES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pms_in_if.sink    i_in,
    pms_out_if.source o_out,
    pms_cfg_if.sink   i_cfg
);
    import pms_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign i_cfg.ready = 1'b1;

    pms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_opcode (i_in.opcode),
        .o_in_ready  (i_in.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    pms_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_vertex_x   (i_in.vertex_x),
        .i_vertex_y   (i_in.vertex_y),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_data   (i_cfg.normal_orientation),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_separation (o_out.separation),
        .o_edge_x     (o_out.edge_x),
        .o_edge_y     (o_out.edge_y),
        .o_point_x    (o_out.point_x),
        .o_point_y    (o_out.point_y),
        .o_status     (o_out.status)
    );

endmodule

/* hw/rtl/pms_check.sv */
// Port-level assertions of the polygon separation block and their binding.
module pms_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic [1:0]         i_in_opcode,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [33:0] i_separation,
    input logic signed [32:0] i_edge_x,
    input logic signed [32:0] i_edge_y,
    input logic signed [31:0] i_point_x,
    input logic signed [31:0] i_point_y,
    input logic [1:0]         i_status
);
    import pms_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_separation) && $stable(i_status))
        else $error("result word changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_opcode == IN_COMPUTE |=> !i_in_ready)
        else $error("input taken during compute");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_A_SHORT || i_status == ST_B_EMPTY) |->
        i_separation == '0 && i_edge_x == '0 && i_edge_y == '0 &&
        i_point_x == '0 && i_point_y == '0)
        else $error("invalid compute returned nonzero fields");

endmodule

bind polygon_min_separation pms_check u_pms_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_opcode  (i_in.opcode),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_separation (o_out.separation),
    .i_edge_x     (o_out.edge_x),
    .i_edge_y     (o_out.edge_y),
    .i_point_x    (o_out.point_x),
    .i_point_y    (o_out.point_y),
    .i_status     (o_out.status)
);
